@@ sv/msr_pkg.sv @@
// Package for the Morse session receiver: register indexes, code bound,
// dictionary and seven-segment tables, lookup helpers.
// No dependencies.
package msr_pkg;

    localparam int MAX_CODE_LEN = 8;
    // Code length counter saturates at the bound or at 15, whichever is lower.
    localparam int CodeBound    = (MAX_CODE_LEN < 15) ? MAX_CODE_LEN : 15;
    localparam int DictSize     = 14;

    localparam int CfgIdxW = 8;
    localparam logic [CfgIdxW-1:0] REG_NOISE_MIN = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_DOT_MAX   = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_DASH_LOW  = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_GAP_LIMIT = 8'd3;

    localparam logic [15:0] NOISE_MIN_RST = 16'd20;
    localparam logic [15:0] DOT_MAX_RST   = 16'd250;
    localparam logic [15:0] DASH_LOW_RST  = 16'd300;
    localparam logic [15:0] GAP_LIMIT_RST = 16'd600;

    typedef enum logic [1:0] {
        ACT_IGNORED = 2'd0,
        ACT_OPENED  = 2'd1,
        ACT_CLOSED  = 2'd2,
        ACT_SHOWN   = 2'd3
    } t_action;

    localparam logic [6:0] CH_UNKNOWN = 7'h3F;  // '?'
    localparam logic [6:0] CH_START   = 7'h3C;  // '<'
    localparam logic [6:0] CH_END     = 7'h3E;  // '>'
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_NINE    = 7'h39;
    localparam logic [6:0] CH_S       = 7'h53;
    localparam logic [6:0] CH_O       = 7'h4F;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_WAIT  = 8'h02;
    localparam logic [7:0] SEG_ERR   = 8'h01;

    localparam logic [6:0] DICT_CHAR [DictSize] = '{
        7'h53, 7'h4F, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34,
        7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3C, 7'h3E
    };
    localparam logic [3:0] DICT_LEN [DictSize] = '{
        4'd3, 4'd3, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6
    };
    localparam logic [7:0] DICT_BITS [DictSize] = '{
        8'h00, 8'h07, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01,
        8'h00, 8'h10, 8'h18, 8'h1C, 8'h1E, 8'h15, 8'h05
    };

    localparam logic [7:0] DIGIT_SEG [10] = '{
        8'hFA, 8'h60, 8'hDC, 8'hF4, 8'h66, 8'hB6, 8'hEE, 8'hE0, 8'hFE, 8'hF6
    };

    // Entries are distinct, so at most one matches.
    function automatic logic [6:0] lookup_code(input logic [3:0] len,
                                               input logic [7:0] bits,
                                               input logic       ovf);
        logic [6:0] ch;
        ch = CH_UNKNOWN;
        for (int i = 0; i < DictSize; i++) begin
            if (DICT_LEN[i] == len && DICT_BITS[i] == bits) begin
                ch = DICT_CHAR[i];
            end
        end
        if (ovf) begin
            ch = CH_UNKNOWN;
        end
        return ch;
    endfunction

    function automatic logic [7:0] char_segments(input logic [6:0] ch);
        logic [6:0] ofs;
        logic [7:0] seg;
        ofs = ch - CH_ZERO;
        seg = SEG_ERR;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            seg = DIGIT_SEG[ofs[3:0]];
        end else if (ch == CH_S) begin
            seg = DIGIT_SEG[5];
        end else if (ch == CH_O) begin
            seg = DIGIT_SEG[0];
        end
        return seg;
    endfunction

endpackage

@@ sv/morse_session_receiver.sv @@
// Morse session receiver top level: pulse timing, code assembly, character
// decode and session tracking. Depends on msr_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one beat per millisecond tick,
//   carrying the sampled line level. Output channel (o_out_valid /
//   i_out_ready): at most one beat per input beat, emitted when a character
//   ends (gap longer than gap_limit after the last kept symbol).
//   The output register loads the result on the clock edge that accepts the
//   input beat that ends the character. Throughput: one input beat per cycle;
//   the single output register limits it only while a result is held.
//   o_in_ready is high when the output register is empty or being drained
//   in the same cycle, so a stalled receiver stalls the input only while a
//   result is waiting.
//   Configuration: i_cfg_we writes register i_cfg_index (0 noise_min,
//   1 dot_max, 2 dash_low, 3 gap_limit); other indexes are ignored.
//   Reset (synchronous, active low) restores default thresholds, clears the
//   code, the timers and the session, and empties the output register.
module morse_session_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_line_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [6:0]                  o_decoded_char,
    output logic [1:0]                  o_action,
    output logic [7:0]                  o_segments,
    output logic                        o_session_open,
    input  logic                        i_cfg_we,
    input  logic [msr_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);

    logic [15:0] r_noise_min, r_dot_max, r_dash_low, r_gap_limit;

    logic        r_pulse_active, n_pulse_active;
    logic [15:0] r_pulse_ticks,  n_pulse_ticks;
    logic [15:0] r_gap_ticks,    n_gap_ticks;
    logic [3:0]  r_code_length,  n_code_length;
    logic [7:0]  r_code_symbols, n_code_symbols;
    logic        r_code_ovf,     n_code_ovf;
    logic        r_in_session,   n_in_session;

    logic        r_out_valid;
    logic [6:0]  r_out_char,     n_out_char;
    logic [1:0]  r_out_action,   n_out_action;
    logic [7:0]  r_out_seg,      n_out_seg;
    logic        r_out_session,  n_out_session;

    logic        accept;
    logic        fire;
    logic        kept;
    logic        is_dash;
    logic [6:0]  ch;
    msr_pkg::t_action act;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_pulse_active = r_pulse_active;
        n_pulse_ticks  = r_pulse_ticks;
        n_gap_ticks    = r_gap_ticks;
        n_code_length  = r_code_length;
        n_code_symbols = r_code_symbols;
        n_code_ovf     = r_code_ovf;
        n_in_session   = r_in_session;
        kept           = 1'b0;
        is_dash        = 1'b0;

        if (i_line_level) begin
            n_pulse_active = 1'b1;
            if (!r_pulse_active) begin
                n_pulse_ticks = 16'd1;
            end else if (r_pulse_ticks != 16'hFFFF) begin
                n_pulse_ticks = r_pulse_ticks + 16'd1;
            end
        end else if (r_pulse_active) begin
            n_pulse_active = 1'b0;
            n_pulse_ticks  = 16'd0;
            if (r_pulse_ticks > r_noise_min) begin
                // dot test wins when thresholds overlap
                if (r_pulse_ticks <= r_dot_max) begin
                    kept = 1'b1;
                end else if (r_pulse_ticks >= r_dash_low) begin
                    kept    = 1'b1;
                    is_dash = 1'b1;
                end
            end
        end

        if (kept) begin
            n_gap_ticks = 16'd0;
            if (r_code_length >= 4'(msr_pkg::CodeBound)) begin
                n_code_ovf = 1'b1;
            end else begin
                n_code_symbols = {r_code_symbols[6:0], is_dash};
                n_code_length  = r_code_length + 4'd1;
            end
        end else if (r_gap_ticks != 16'hFFFF) begin
            n_gap_ticks = r_gap_ticks + 16'd1;
        end

        fire = (n_code_length != 4'd0 || n_code_ovf) && (n_gap_ticks > r_gap_limit);
        ch   = msr_pkg::lookup_code(n_code_length, n_code_symbols, n_code_ovf);

        act       = msr_pkg::ACT_IGNORED;
        n_out_seg = msr_pkg::SEG_WAIT;
        if (!r_in_session) begin
            if (ch == msr_pkg::CH_START) begin
                act       = msr_pkg::ACT_OPENED;
                n_out_seg = msr_pkg::SEG_BLANK;
            end
        end else if (ch == msr_pkg::CH_END) begin
            act = msr_pkg::ACT_CLOSED;
        end else begin
            act       = msr_pkg::ACT_SHOWN;
            n_out_seg = msr_pkg::char_segments(ch);
        end

        if (fire) begin
            n_code_length  = 4'd0;
            n_code_symbols = 8'd0;
            n_code_ovf     = 1'b0;
            if (act == msr_pkg::ACT_OPENED) begin
                n_in_session = 1'b1;
            end else if (act == msr_pkg::ACT_CLOSED) begin
                n_in_session = 1'b0;
            end
        end

        n_out_char    = ch;
        n_out_action  = act;
        n_out_session = n_in_session;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_min <= msr_pkg::NOISE_MIN_RST;
            r_dot_max   <= msr_pkg::DOT_MAX_RST;
            r_dash_low  <= msr_pkg::DASH_LOW_RST;
            r_gap_limit <= msr_pkg::GAP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msr_pkg::REG_NOISE_MIN: r_noise_min <= i_cfg_data;
                msr_pkg::REG_DOT_MAX:   r_dot_max   <= i_cfg_data;
                msr_pkg::REG_DASH_LOW:  r_dash_low  <= i_cfg_data;
                msr_pkg::REG_GAP_LIMIT: r_gap_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_active <= 1'b0;
            r_pulse_ticks  <= 16'd0;
            r_gap_ticks    <= 16'd0;
            r_code_length  <= 4'd0;
            r_code_symbols <= 8'd0;
            r_code_ovf     <= 1'b0;
            r_in_session   <= 1'b0;
        end else if (accept) begin
            r_pulse_active <= n_pulse_active;
            r_pulse_ticks  <= n_pulse_ticks;
            r_gap_ticks    <= n_gap_ticks;
            r_code_length  <= n_code_length;
            r_code_symbols <= n_code_symbols;
            r_code_ovf     <= n_code_ovf;
            r_in_session   <= n_in_session;
        end
    end

    // output register: loads on a beat that ends a character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && fire) begin
            r_out_char    <= n_out_char;
            r_out_action  <= n_out_action;
            r_out_seg     <= n_out_seg;
            r_out_session <= n_out_session;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_decoded_char = r_out_char;
    assign o_action       = r_out_action;
    assign o_segments     = r_out_seg;
    assign o_session_open = r_out_session;

endmodule

@@ tb/morse_session_receiver_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for morse_session_receiver: drives line-level ticks and
// threshold writes, predicts every decoded character and checks it beat by beat.
// Depends on msr_pkg and the morse_session_receiver RTL.
module morse_session_receiver_tb;

    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int CODE_CAP = (msr_pkg::MAX_CODE_LEN < 15) ? msr_pkg::MAX_CODE_LEN : 15;

    localparam logic [15:0] DEF_NOISE_MIN = 16'd20;
    localparam logic [15:0] DEF_DOT_MAX   = 16'd250;
    localparam logic [15:0] DEF_DASH_LOW  = 16'd300;
    localparam logic [15:0] DEF_GAP_LIMIT = 16'd600;

    localparam logic [7:0] DISP_BLANK = 8'h00;
    localparam logic [7:0] DISP_WAIT  = 8'h02;
    localparam logic [7:0] DISP_ERR   = 8'h01;

    // Dictionary: S O 0-9 < >, symbols oldest first down to bit 0, dash = 1
    localparam int N_CODES    = 14;
    localparam int N_SHOWABLE = 12;
    localparam int IDX_START  = 12;
    localparam int IDX_END    = 13;
    localparam logic [6:0] MORSE_CHAR [N_CODES] = '{
        7'h53, 7'h4F, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34,
        7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3C, 7'h3E
    };
    localparam logic [3:0] MORSE_LEN [N_CODES] = '{
        4'd3, 4'd3, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6
    };
    localparam logic [7:0] MORSE_BITS [N_CODES] = '{
        8'h00, 8'h07, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01,
        8'h00, 8'h10, 8'h18, 8'h1C, 8'h1E, 8'h15, 8'h05
    };
    localparam logic [7:0] DIGIT_PATTERN [10] = '{
        8'hFA, 8'h60, 8'hDC, 8'hF4, 8'h66, 8'hB6, 8'hEE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct packed {
        logic [6:0]       ch;
        msr_pkg::t_action act;
        logic [7:0]       seg;
        logic             sess;
    } t_morse_result;

    class char_scoreboard;
        logic [15:0]   noise_min, dot_max, dash_low, gap_limit;
        bit            in_pulse;
        logic [15:0]   pulse_len, gap_len;
        logic [3:0]    sym_count;
        logic [7:0]    sym_bits;
        bit            too_long, in_session;
        t_morse_result pending[$];
        int unsigned   errors, results_seen;

        function new();
            noise_min    = DEF_NOISE_MIN;
            dot_max      = DEF_DOT_MAX;
            dash_low     = DEF_DASH_LOW;
            gap_limit    = DEF_GAP_LIMIT;
            in_pulse     = 1'b0;
            pulse_len    = '0;
            gap_len      = '0;
            sym_count    = '0;
            sym_bits     = '0;
            too_long     = 1'b0;
            in_session   = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] val);
            case (idx)
                msr_pkg::REG_NOISE_MIN: noise_min = val;
                msr_pkg::REG_DOT_MAX:   dot_max = val;
                msr_pkg::REG_DASH_LOW:  dash_low = val;
                msr_pkg::REG_GAP_LIMIT: gap_limit = val;
                default: ;
            endcase
        endfunction

        function void add_symbol(bit dash);
            if (sym_count >= CODE_CAP) begin
                too_long = 1'b1;
            end else begin
                sym_bits  = {sym_bits[6:0], dash};
                sym_count = sym_count + 1'b1;
            end
            gap_len = '0;
        endfunction

        // One accepted input beat; queues the character it completes, if any.
        function void note_tick(bit level);
            bit            kept;
            logic [15:0]   width;
            logic [6:0]    ofs;
            t_morse_result r;
            kept = 1'b0;
            r.ch = msr_pkg::CH_UNKNOWN;
            if (level) begin
                if (!in_pulse) begin
                    in_pulse  = 1'b1;
                    pulse_len = 16'd1;
                end else if (pulse_len != 16'hFFFF) begin
                    pulse_len = pulse_len + 1'b1;
                end
            end else if (in_pulse) begin
                width     = pulse_len;
                in_pulse  = 1'b0;
                pulse_len = '0;
                if (width > noise_min) begin
                    // dot test wins when the thresholds overlap
                    if (width <= dot_max) begin
                        add_symbol(1'b0);
                        kept = 1'b1;
                    end else if (width >= dash_low) begin
                        add_symbol(1'b1);
                        kept = 1'b1;
                    end
                end
            end
            if (!kept && gap_len != 16'hFFFF) begin
                gap_len = gap_len + 1'b1;
            end
            if ((sym_count == 0 && !too_long) || gap_len <= gap_limit) begin
                return;
            end
            if (!too_long) begin
                for (int k = 0; k < N_CODES; k++) begin
                    if (MORSE_LEN[k] == sym_count && MORSE_BITS[k] == sym_bits) begin
                        r.ch = MORSE_CHAR[k];
                    end
                end
            end
            sym_count = '0;
            sym_bits  = '0;
            too_long  = 1'b0;
            if (!in_session) begin
                if (r.ch == msr_pkg::CH_START) begin
                    in_session = 1'b1;
                    r.act      = msr_pkg::ACT_OPENED;
                    r.seg      = DISP_BLANK;
                end else begin
                    r.act = msr_pkg::ACT_IGNORED;
                    r.seg = DISP_WAIT;
                end
            end else if (r.ch == msr_pkg::CH_END) begin
                in_session = 1'b0;
                r.act      = msr_pkg::ACT_CLOSED;
                r.seg      = DISP_WAIT;
            end else begin
                r.act = msr_pkg::ACT_SHOWN;
                ofs   = r.ch - msr_pkg::CH_ZERO;
                if (r.ch >= msr_pkg::CH_ZERO && r.ch <= msr_pkg::CH_NINE) begin
                    r.seg = DIGIT_PATTERN[ofs[3:0]];
                end else if (r.ch == msr_pkg::CH_S) begin
                    r.seg = DIGIT_PATTERN[5];
                end else if (r.ch == msr_pkg::CH_O) begin
                    r.seg = DIGIT_PATTERN[0];
                end else begin
                    r.seg = DISP_ERR;
                end
            end
            r.sess = in_session;
            pending.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30) begin
                $display("MISMATCH @%0t: %s", $realtime, msg);
            end
        endtask

        task check_result(t_morse_result got);
            t_morse_result want;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat char=%0h act=%0d seg=%0h sess=%0b",
                                 got.ch, got.act, got.seg, got.sess));
                return;
            end
            want = pending.pop_front();
            if (got.ch !== want.ch) begin
                report($sformatf("decoded_char %0h, want %0h", got.ch, want.ch));
            end
            if (got.act !== want.act) begin
                report($sformatf("action %0d, want %0d (char %0h)", got.act, want.act, want.ch));
            end
            if (got.seg !== want.seg) begin
                report($sformatf("segments %0h, want %0h (char %0h)", got.seg, want.seg, want.ch));
            end
            if (got.sess !== want.sess) begin
                report($sformatf("session_open %0b, want %0b (char %0h)",
                                 got.sess, want.sess, want.ch));
            end
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_line_level = 1'b0;
    logic        i_out_ready  = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [7:0]  i_cfg_index  = '0;
    logic [15:0] i_cfg_data   = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [6:0]  o_decoded_char;
    logic [1:0]  o_action;
    logic [7:0]  o_segments;
    logic        o_session_open;

    char_scoreboard sb;
    t_morse_result  seen;
    logic           hold_off      = 1'b0;
    int             in_idle_pct   = 0;
    int             out_stall_pct = 0;
    int             ticks_sent    = 0;
    int unsigned    cycle_count   = 0;

    // timing the stimulus is shaped for, tracks the last register writes
    int cur_noise = int'(DEF_NOISE_MIN);
    int cur_dot   = int'(DEF_DOT_MAX);
    int cur_dash  = int'(DEF_DASH_LOW);
    int cur_gap   = int'(DEF_GAP_LIMIT);

    morse_session_receiver uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_level   (i_line_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_decoded_char (o_decoded_char),
        .o_action       (o_action),
        .o_segments     (o_segments),
        .o_session_open (o_session_open),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check each accepted beat, stall at random or during a hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            seen.ch   = o_decoded_char;
            seen.act  = msr_pkg::t_action'(o_action);
            seen.seg  = o_segments;
            seen.sess = o_session_open;
            sb.check_result(seen);
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= out_stall_pct);
    end

    task automatic send_tick(input bit level);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_line_level <= level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_tick(level);
        ticks_sent++;
    endtask

    task automatic send_pulse(input int high, input int low);
        repeat (high) send_tick(1'b1);
        repeat (low) send_tick(1'b0);
    endtask

    function automatic int dot_ticks();
        int lo;
        lo = cur_noise + 1;
        if (cur_dot <= lo) return lo;
        if (cur_dot - lo <= 6) return $urandom_range(cur_dot, lo);
        if ($urandom_range(1)) return $urandom_range(cur_dot, cur_dot - 3);
        return $urandom_range(lo + 3, lo);
    endfunction

    function automatic int dash_ticks();
        int lo;
        lo = cur_dash;
        if (lo <= cur_dot) lo = cur_dot + 1;
        if (lo <= cur_noise) lo = cur_noise + 1;
        return lo + $urandom_range(3);
    endfunction

    // Symbols go out oldest first; noisy adds pulses that must be dropped.
    task automatic send_code(input int len, input logic [15:0] bits, input bit noisy);
        for (int i = len - 1; i >= 0; i--) begin
            send_pulse(bits[i] ? dash_ticks() : dot_ticks(), $urandom_range(2, 1));
            if (noisy && $urandom_range(3) == 0) begin
                if (cur_noise > 0 && $urandom_range(1)) begin
                    send_pulse($urandom_range(cur_noise, 1), 1);
                end else if (cur_dash > cur_dot + 1) begin
                    send_pulse(cur_dot + 1, 1);
                end
            end
        end
        send_pulse(0, cur_gap + 1 + $urandom_range(2));
    endtask

    task automatic send_dict(input int idx, input bit noisy);
        send_code(int'(MORSE_LEN[idx]), 16'(MORSE_BITS[idx]), noisy);
    endtask

    task automatic send_random_char();
        int          pick;
        logic [15:0] bits;
        pick = $urandom_range(99);
        bits = 16'($urandom);
        if (pick < 12) begin
            send_dict(IDX_START, $urandom_range(3) == 0);
        end else if (pick < 20) begin
            send_dict(IDX_END, $urandom_range(3) == 0);
        end else if (pick < 75) begin
            send_dict(int'($urandom_range(N_SHOWABLE - 1)), $urandom_range(3) == 0);
        end else if (pick < 90) begin
            send_code($urandom_range(11, 1), bits, 1'b1);
        end else begin
            repeat ($urandom_range(12, 1)) send_tick(1'($urandom_range(1)));
        end
    endtask

    // Drain: no more beats offered, all expected characters in, block quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // All four thresholds, then a write to an unmapped index that must be ignored.
    task automatic program_timing(input int nmin, input int dmax, input int dmin, input int tmo);
        logic [7:0]  stray_idx;
        logic [15:0] stray_val;
        stray_idx = msr_pkg::REG_GAP_LIMIT + 8'd1 + 8'($urandom_range(251));
        stray_val = 16'($urandom);
        i_cfg_we <= 1'b1;
        write_cfg(msr_pkg::REG_NOISE_MIN, 16'(nmin));
        write_cfg(msr_pkg::REG_DOT_MAX, 16'(dmax));
        write_cfg(msr_pkg::REG_DASH_LOW, 16'(dmin));
        write_cfg(msr_pkg::REG_GAP_LIMIT, 16'(tmo));
        write_cfg(stray_idx, stray_val);
        i_cfg_we <= 1'b0;
        cur_noise = nmin;
        cur_dot   = dmax;
        cur_dash  = dmin;
        cur_gap   = tmo;
    endtask

    task automatic hold_receiver(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off <= 1'b0;
    endtask

    initial begin
        int          phase_ticks;
        int unsigned phase_results;
        int          nmin, dmax, dmin;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: noise edge, then shortest dot; the short timeout below ends it
        send_pulse(20, 1);
        send_pulse(21, 1);
        settle();

        // directed: boundaries, every action, session corner cases
        program_timing(1, 2, 4, 9);
        send_pulse(0, cur_gap + 2);
        send_dict(0, 1'b0);                 // S while waiting is ignored
        send_pulse(1, 1);
        send_pulse(2, 1);
        send_pulse(3, 1);
        send_pulse(4, 1);
        send_pulse(0, cur_gap + 2);
        send_dict(IDX_START, 1'b0);
        send_dict(IDX_START, 1'b0);         // start mark again inside the session
        for (int k = 0; k < N_SHOWABLE; k++) begin
            send_dict(k, k[0]);
        end
        send_code(4, 16'h0000, 1'b0);       // valid Morse but not in the dictionary
        send_code(CODE_CAP, 16'($urandom), 1'b0);
        send_code(CODE_CAP + 1, 16'($urandom), 1'b0);
        // a pulse longer than the timeout ends the character while still high
        send_pulse(dot_ticks(), 1);
        send_pulse(cur_gap + 5, 1);
        send_pulse(0, cur_gap + 2);
        send_dict(IDX_END, 1'b0);
        settle();

        // register extremes
        program_timing(0, 0, 0, 0);
        repeat (30) send_tick(1'($urandom_range(1)));
        settle();
        program_timing(1, 6, 3, 14);        // dash_low below dot_max
        repeat (3) send_random_char();
        settle();
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (20) send_tick(1'($urandom_range(1)));
        settle();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 86; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 86; end
                default: begin in_idle_pct = 13; out_stall_pct = 13; end
            endcase
            nmin = $urandom_range(3);
            dmax = nmin + $urandom_range(4, 1);
            dmin = ($urandom_range(4) == 0) ? dmax - $urandom_range(1)
                                            : dmax + $urandom_range(3, 1);
            program_timing(nmin, dmax, dmin, dmin + 8 + $urandom_range(6));
            phase_ticks   = ticks_sent;
            phase_results = sb.results_seen;
            if (mode == 0) begin
                // long receiver stall while characters keep coming
                fork
                    hold_receiver(300);
                    repeat (3) send_random_char();
                join
            end
            while (ticks_sent - phase_ticks < 60 || sb.results_seen - phase_results < 2) begin
                send_random_char();
            end
            settle();
        end

        in_idle_pct   = 0;
        out_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/msr_pkg.sv
sv/morse_session_receiver.sv
tb/morse_session_receiver_tb.sv
